[sv/scan_points_to_world_xy_defines.svh]
// Assertion macros for the scan-to-world point block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SCAN_POINTS_TO_WORLD_XY_DEFINES_SVH
`define SCAN_POINTS_TO_WORLD_XY_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SPTW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sptw check failed");
// Check a property on every rising clock edge, reset included.
`define SPTW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sptw check failed");
`else
`define SPTW_ASSERT(label, clk, rst, prop)
`define SPTW_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[sv/sptw_pkg.sv]
// Shared types, constants and the quarter-wave sine generator for the
// scan-to-world point block. No dependencies.
package sptw_pkg;

  localparam int RANGE_W = 16;
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int FIELD12_W = 12;
  localparam int TRIG_W = 15;

  localparam longint PI_HALF_Q30 = 64'sd1686629713;

  // Denominators (2i+2)(2i+3) of the Taylor series
  localparam longint TAYLOR_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  typedef enum logic [2:0] {
    REG_POSE_X       = 3'd0,
    REG_POSE_Y       = 3'd1,
    REG_HEADING      = 3'd2,
    REG_ANGLE_STEP   = 3'd3,
    REG_CENTER_INDEX = 3'd4,
    REG_MIN_RANGE    = 3'd5,
    REG_MAX_RANGE    = 3'd6,
    REG_DECIMATION   = 3'd7
  } reg_index_t;

  // Quarter-wave sine entry k in unsigned Q0.15, for a table of 2^(bits-2) steps.
  function automatic logic [TRIG_W-1:0] sin_entry(input int bits, input int k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x = (PI_HALF_Q30 * longint'(k)) >>> (bits - 2);
    x2 = (x * x) >>> 30;
    term = x;
    sum = 0;
    for (int i = 0; i < 9; i++) begin
      if ((i % 2) == 1) sum = sum - term;
      else sum = sum + term;
      term = ((term * x2) >>> 30) / TAYLOR_DIV[i];
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return TRIG_W'(sum);
  endfunction

endpackage

[sv/sptw_beam_if.sv]
// Beam sample channel: valid/ready handshake carrying one range sample.
// Depends on sptw_pkg for field widths.
interface sptw_beam_if import sptw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               scan_end;

  modport source (output valid, output range_mm, output scan_end, input ready);
  modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

[sv/sptw_point_if.sv]
// World point channel: valid/ready handshake carrying one converted beam.
// Depends on sptw_pkg for field widths.
interface sptw_point_if import sptw_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        kept;
  logic signed [COORD_W-1:0]   x_world;
  logic signed [COORD_W-1:0]   y_world;
  logic [FIELD12_W-1:0]        beam_index;
  logic                        scan_last;

  modport source (output valid, output kept, output x_world, output y_world,
                  output beam_index, output scan_last, input ready);
  modport sink   (input valid, input kept, input x_world, input y_world,
                  input beam_index, input scan_last, output ready);
endinterface

[sv/scan_points_to_world_xy.sv]
// Channel    | Dir | Handshake     | Payload
// beam_in    | in  | valid / ready | range_mm[15:0], scan_end
// point_out  | out | valid / ready | kept, x_world[31:0], y_world[31:0],
//            |     |               | beam_index[11:0], scan_last
// apb        | in  | psel/penable  | paddr[4:0], pwdata[31:0], prdata[31:0], pready
//
// One request per cycle sustained while point_out.ready holds. Each request passes
// in order through the five register stages, which are input register,
// angle/address, sine ROM read, multiply, add.
// The ROM read stage and the r*trig multiply set the per-stage depth.
// Each stage holds its request while the next one is full, so requests keep
// entering until all five stages are occupied. rst is synchronous, clears the
// stage valids, the beam counter, the skip countdown and the registers.
// Depends on sptw_pkg, sptw_beam_if, sptw_point_if and the defines header.
`include "scan_points_to_world_xy_defines.svh"

module scan_points_to_world_xy import sptw_pkg::*; #(
  parameter int MAX_BEAMS       = 4096,
  parameter int TRIG_TABLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  sptw_beam_if.sink           beam_in,
  sptw_point_if.source        point_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CNT_W  = $clog2(MAX_BEAMS);
  localparam int QTR    = 1 << (TRIG_TABLE_BITS - 2);
  localparam int RR_W   = TRIG_TABLE_BITS - 2;
  localparam int TAB_AW = TRIG_TABLE_BITS - 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BEAMS - 1);

  // ---------------------------------------------------------------- config
  logic signed [COORD_W-1:0] pose_x;
  logic signed [COORD_W-1:0] pose_y;
  logic [ANGLE_W-1:0]        heading;
  logic [FIELD12_W-1:0]      angle_step;
  logic [FIELD12_W-1:0]      center_index;
  logic [RANGE_W-1:0]        min_range;
  logic [RANGE_W-1:0]        max_range;
  logic [FIELD12_W-1:0]      decimation;
  reg_index_t                reg_sel;

  assign reg_sel = reg_index_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      heading      <= '0;
      angle_step   <= '0;
      center_index <= '0;
      min_range    <= '0;
      max_range    <= '1;
      decimation   <= FIELD12_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_POSE_X:       pose_x       <= pwdata;
        REG_POSE_Y:       pose_y       <= pwdata;
        REG_HEADING:      heading      <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_STEP:   angle_step   <= pwdata[FIELD12_W-1:0];
        REG_CENTER_INDEX: center_index <= pwdata[FIELD12_W-1:0];
        REG_MIN_RANGE:    min_range    <= pwdata[RANGE_W-1:0];
        REG_MAX_RANGE:    max_range    <= pwdata[RANGE_W-1:0];
        REG_DECIMATION:   decimation   <= pwdata[FIELD12_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POSE_X:       prdata = pose_x;
      REG_POSE_Y:       prdata = pose_y;
      REG_HEADING:      prdata = 32'(heading);
      REG_ANGLE_STEP:   prdata = 32'(angle_step);
      REG_CENTER_INDEX: prdata = 32'(center_index);
      REG_MIN_RANGE:    prdata = 32'(min_range);
      REG_MAX_RANGE:    prdata = 32'(max_range);
      REG_DECIMATION:   prdata = 32'(decimation);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- stage enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  logic accept;

  assign en5 = !point_out.valid || point_out.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign beam_in.ready = en1;
  assign accept = beam_in.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
      v4              <= 1'b0;
      point_out.valid <= 1'b0;
    end else begin
      if (en1) v1 <= beam_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) point_out.valid <= v4;
    end
  end

  // ------------------------------------------------- beam counter and skip
  logic [CNT_W-1:0]     beam_counter;
  logic [CNT_W-1:0]     beam_counter_next;
  logic [FIELD12_W-1:0] skip_countdown;
  logic [FIELD12_W-1:0] skip_countdown_next;
  logic [FIELD12_W-1:0] dec_m1;
  logic                 considered;

  always_comb begin
    dec_m1 = (decimation == '0) ? '0 : decimation - FIELD12_W'(1);
    considered = (skip_countdown == '0);
    skip_countdown_next = considered ? dec_m1 : skip_countdown - FIELD12_W'(1);
    beam_counter_next = (beam_counter == CNT_LAST) ? '0 : beam_counter + CNT_W'(1);
    // clear after the last beam of the scan
    if (beam_in.scan_end) begin
      beam_counter_next   = '0;
      skip_countdown_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_counter   <= '0;
      skip_countdown <= '0;
    end else if (accept) begin
      beam_counter   <= beam_counter_next;
      skip_countdown <= skip_countdown_next;
    end
  end

  // ------------------------------------------------------ stage 1: input reg
  logic [RANGE_W-1:0] s1_range;
  logic               s1_last;
  logic [ANGLE_W-1:0] s1_idx;
  logic               s1_cons;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_range <= beam_in.range_mm;
      s1_last  <= beam_in.scan_end;
      s1_idx   <= ANGLE_W'(beam_counter);
      s1_cons  <= considered;
    end
  end

  // ------------------------------------------- stage 2: angle, ROM address
  logic                       kept2;
  logic [ANGLE_W-1:0]         diff16;
  logic [ANGLE_W-1:0]         step_prod;
  logic [ANGLE_W-1:0]         angle2;
  logic [TRIG_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                 sin_quad;
  logic [1:0]                 cos_quad;
  logic [RR_W-1:0]            rr;
  logic [TAB_AW-1:0]          rr_ext;
  logic [TAB_AW-1:0]          rr_mirror;

  always_comb begin
    kept2     = s1_cons && (s1_range > min_range) && (s1_range < max_range);
    diff16    = s1_idx - ANGLE_W'(center_index);
    step_prod = ANGLE_W'(angle_step * diff16);
    angle2    = heading + step_prod;
    tab_idx   = angle2[ANGLE_W-1 -: TRIG_TABLE_BITS];
    sin_quad  = tab_idx[TRIG_TABLE_BITS-1 -: 2];
    cos_quad  = sin_quad + 2'd1;  // quarter turn ahead
    rr        = tab_idx[RR_W-1:0];
    rr_ext    = TAB_AW'(rr);
    rr_mirror = TAB_AW'(QTR) - rr_ext;
  end

  logic [TAB_AW-1:0]    s2_sin_addr;
  logic [TAB_AW-1:0]    s2_cos_addr;
  logic                 s2_sin_neg;
  logic                 s2_cos_neg;
  logic                 s2_kept;
  logic [RANGE_W-1:0]   s2_range;
  logic                 s2_last;
  logic [FIELD12_W-1:0] s2_idx;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sin_addr <= sin_quad[0] ? rr_mirror : rr_ext;
      s2_cos_addr <= cos_quad[0] ? rr_mirror : rr_ext;
      s2_sin_neg  <= sin_quad[1];
      s2_cos_neg  <= cos_quad[1];
      s2_kept     <= kept2;
      s2_range    <= s1_range;
      s2_last     <= s1_last;
      s2_idx      <= s1_idx[FIELD12_W-1:0];
    end
  end

  // ------------------------------------------------ stage 3: sine ROM read
  logic [TRIG_W-1:0] sin_rom [QTR+1];

  for (genvar k = 0; k <= QTR; k++) begin : g_rom
    assign sin_rom[k] = sin_entry(TRIG_TABLE_BITS, k);
  end

  logic [TRIG_W-1:0]    s3_sin_mag;
  logic [TRIG_W-1:0]    s3_cos_mag;
  logic                 s3_sin_neg;
  logic                 s3_cos_neg;
  logic                 s3_kept;
  logic [RANGE_W-1:0]   s3_range;
  logic                 s3_last;
  logic [FIELD12_W-1:0] s3_idx;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sin_mag <= sin_rom[s2_sin_addr];
      s3_cos_mag <= sin_rom[s2_cos_addr];
      s3_sin_neg <= s2_sin_neg;
      s3_cos_neg <= s2_cos_neg;
      s3_kept    <= s2_kept;
      s3_range   <= s2_range;
      s3_last    <= s2_last;
      s3_idx     <= s2_idx;
    end
  end

  // ----------------------------------------------------- stage 4: multiply
  logic signed [TRIG_W:0]         sin_t;
  logic signed [TRIG_W:0]         cos_t;
  logic signed [RANGE_W:0]        r_s;
  logic signed [RANGE_W+TRIG_W+1:0] prod_x;
  logic signed [RANGE_W+TRIG_W+1:0] prod_y;

  always_comb begin
    sin_t  = s3_sin_neg ? -$signed({1'b0, s3_sin_mag}) : $signed({1'b0, s3_sin_mag});
    cos_t  = s3_cos_neg ? -$signed({1'b0, s3_cos_mag}) : $signed({1'b0, s3_cos_mag});
    r_s    = $signed({1'b0, s3_range});
    prod_x = r_s * cos_t;
    prod_y = r_s * sin_t;
  end

  logic signed [RANGE_W:0] s4_dx;
  logic signed [RANGE_W:0] s4_dy;
  logic                    s4_kept;
  logic                    s4_last;
  logic [FIELD12_W-1:0]    s4_idx;

  always_ff @(posedge clk) begin
    if (en4) begin
      // floor shift by 15; magnitude stays below 2^31
      s4_dx   <= prod_x[31:15];
      s4_dy   <= prod_y[31:15];
      s4_kept <= s3_kept;
      s4_last <= s3_last;
      s4_idx  <= s3_idx;
    end
  end

  // --------------------------------------------- stage 5: add and saturate
  logic signed [COORD_W:0]   sum_x;
  logic signed [COORD_W:0]   sum_y;
  logic signed [COORD_W-1:0] sat_x;
  logic signed [COORD_W-1:0] sat_y;

  always_comb begin
    sum_x = {pose_x[COORD_W-1], pose_x} + {{(COORD_W-RANGE_W){s4_dx[RANGE_W]}}, s4_dx};
    sum_y = {pose_y[COORD_W-1], pose_y} + {{(COORD_W-RANGE_W){s4_dy[RANGE_W]}}, s4_dy};
    if (sum_x[COORD_W] != sum_x[COORD_W-1])
      sat_x = sum_x[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    else
      sat_x = sum_x[COORD_W-1:0];
    if (sum_y[COORD_W] != sum_y[COORD_W-1])
      sat_y = sum_y[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    else
      sat_y = sum_y[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      point_out.kept       <= s4_kept;
      point_out.x_world    <= s4_kept ? sat_x : '0;
      point_out.y_world    <= s4_kept ? sat_y : '0;
      point_out.beam_index <= s4_idx;
      point_out.scan_last  <= s4_last;
    end
  end

  // ----------------------------------------------------------- assertions
  `SPTW_ASSERT(a_drop_zero, clk, rst,
    (point_out.valid && !point_out.kept) |-> (point_out.x_world == '0 && point_out.y_world == '0))
  `SPTW_ASSERT(a_scan_clear, clk, rst,
    (accept && beam_in.scan_end) |=> (beam_counter == '0 && skip_countdown == '0))
  `SPTW_ASSERT(a_stall_full, clk, rst,
    !beam_in.ready |-> (v1 && v2 && v3 && v4 && point_out.valid))
  `SPTW_ASSERT_ALWAYS(a_pready_high, clk,
    pready)

endmodule
